// ===== sv/mpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mpc_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int ALPHABET   = 26;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = NODE_W + 1;
    localparam int LET_W      = $clog2(ALPHABET);
    localparam int SLOT_W     = $clog2(MAX_NODES * ALPHABET);
    localparam int REQ_W      = 3;
    localparam int LETTER_W   = 5;
    localparam int COUNT_W    = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [REQ_W-1:0] REQ_PAT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ENDP  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BUILD = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TEXT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ENDT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [LETTER_W-1:0] letter;
    } t_op;

    typedef logic [ALPHABET-1:0] t_mask;

    // flat index of one goto edge
    function automatic logic [SLOT_W-1:0] slot(input logic [NODE_W-1:0] nd,
                                               input logic [LET_W-1:0] c);
        slot = SLOT_W'(nd) * SLOT_W'(ALPHABET) + SLOT_W'(c);
    endfunction

endpackage
`default_nettype wire

// ===== sv/mpc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface mpc_req_if
    import mpc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, output req_type, output letter, input ready);
    modport sink   (input valid, input req_type, input letter, output ready);
endinterface

interface mpc_rsp_if
    import mpc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;
    logic               table_full;

    modport source (output valid, output match_count, output table_full, input ready);
    modport sink   (input valid, input match_count, input table_full, output ready);
endinterface
`default_nettype wire

// ===== sv/multi_pattern_presence_counter.sv =====
// Aho-Corasick multi-pattern matcher.
// i_req carries request words (req_type, letter): pattern letters and end
// of pattern grow the trie, build computes failure links, text letters step
// the automaton, end of text gives one word on o_rsp (match_count, table_full),
// clear empties everything. Other requests give no word.
// A front stage takes words into a four-entry queue whenever it has room;
// an engine drains the queue. Text letters and end of pattern each take one
// read (of the edge memory, or of the counts for end of pattern) and one
// update; a pattern letter that adds a node also clears the new node's mask.
// Build walks the root row and then each node in breadth-first order, bound
// by the single read port of the edge memory. End of text moves the marks
// up the failure links of the built nodes, then sums the counts of every
// marked trie node before the result. Reset and clear empty the root
// entries; no other clearing pass is needed. The result sits in an output
// register; while the receiver stalls, the engine keeps working on later
// words and only waits when a second result is ready.
`timescale 1ns / 1ps
`default_nettype none
module multi_pattern_presence_counter
    import mpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mpc_req_if.sink   i_req,
    mpc_rsp_if.source o_rsp
);

    logic w_full, w_empty, w_push, w_pop;
    t_op  w_in_op, w_q_op;

    mpc_front u_front (
        .i_req  (i_req),
        .i_full (w_full),
        .o_push (w_push),
        .o_op   (w_in_op)
    );

    mpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_in_op),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_op    (w_q_op)
    );

    mpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_op    (w_q_op),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

// ===== sv/mpc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mpc_front
    import mpc_pkg::*;
(
    mpc_req_if.sink   i_req,
    input  wire logic i_full,
    output logic      o_push,
    output t_op       o_op
);

    logic w_keep;

    // words with no effect are taken and dropped here
    always_comb begin
        if (i_req.req_type == REQ_PAT || i_req.req_type == REQ_TEXT) begin
            w_keep = (i_req.letter < LETTER_W'(ALPHABET));
        end else begin
            w_keep = (i_req.req_type <= REQ_CLEAR);
        end
    end

    assign i_req.ready    = !i_full;
    assign o_push         = i_req.valid && !i_full && w_keep;
    assign o_op.req_type  = i_req.req_type;
    assign o_op.letter    = i_req.letter;

endmodule
`default_nettype wire

// ===== sv/mpc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mpc_fifo
    import mpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_op       o_op
);

    t_op                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_push, w_pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            if (w_push && !w_pop) r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_op;
    end

endmodule
`default_nettype wire

// ===== sv/mpc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mpc_back
    import mpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_op  i_op,
    output logic      o_pop,
    mpc_rsp_if.source o_rsp
);

    localparam logic [4:0] S_INIT    = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_PAT_RD  = 5'd2;
    localparam logic [4:0] S_PAT_NEW = 5'd3;
    localparam logic [4:0] S_END_RD  = 5'd4;
    localparam logic [4:0] S_TXT_RD  = 5'd5;
    localparam logic [4:0] S_BR_RQ   = 5'd6;
    localparam logic [4:0] S_BR_DO   = 5'd7;
    localparam logic [4:0] S_BH      = 5'd8;
    localparam logic [4:0] S_BPAR    = 5'd9;
    localparam logic [4:0] S_BVIA    = 5'd10;
    localparam logic [4:0] S_BC_RQ   = 5'd11;
    localparam logic [4:0] S_BC_KID  = 5'd12;
    localparam logic [4:0] S_BC_TGT  = 5'd13;
    localparam logic [4:0] S_FR_RQ   = 5'd14;
    localparam logic [4:0] S_FR_ND   = 5'd15;
    localparam logic [4:0] S_FR_UP   = 5'd16;
    localparam logic [4:0] S_FS_RQ   = 5'd17;
    localparam logic [4:0] S_FS_DO   = 5'd18;
    localparam logic [4:0] S_OUT     = 5'd19;

    localparam logic [LET_W-1:0] LAST_C = LET_W'(ALPHABET - 1);

    // memories: goto edges with a per-node written mask, links, counts, marks, order
    logic [NODE_W-1:0]  ch_mem [MAX_NODES*ALPHABET];
    t_mask              msk_mem [MAX_NODES];
    logic [NODE_W-1:0]  fl_mem [MAX_NODES];
    logic [COUNT_W-1:0] ec_mem [MAX_NODES];
    logic               vm_mem [MAX_NODES];
    logic [NODE_W-1:0]  bo_mem [MAX_NODES];

    logic [NODE_W-1:0]  r_ch_q, r_fl_q, r_bo_q;
    t_mask              r_msk_q;
    logic [COUNT_W-1:0] r_ec_q;
    logic               r_vm_q;

    logic [SLOT_W-1:0]  ch_raddr, ch_waddr;
    logic [NODE_W-1:0]  ch_wdata;
    logic               ch_we;
    logic [NODE_W-1:0]  msk_raddr, msk_waddr;
    t_mask              msk_wdata;
    logic               msk_we;
    logic [NODE_W-1:0]  fl_raddr, fl_waddr, fl_wdata;
    logic               fl_we;
    logic [NODE_W-1:0]  ec_raddr, ec_waddr;
    logic [COUNT_W-1:0] ec_wdata;
    logic               ec_we;
    logic [NODE_W-1:0]  vm_raddr, vm_waddr;
    logic               vm_wdata, vm_we;
    logic [NODE_W-1:0]  bo_raddr, bo_waddr, bo_wdata;
    logic               bo_we;

    logic [4:0]         r_state, n_state;
    logic [NODE_W-1:0]  r_cursor, n_cursor, r_scan, n_scan;
    logic [CNT_W-1:0]   r_ncount, n_ncount, r_olen, n_olen, r_idx, n_idx;
    logic               r_ovf, n_ovf, r_void, n_void, r_built, n_built;
    logic [LET_W-1:0]   r_let, n_let, r_c, n_c;
    logic [NODE_W-1:0]  r_parent, n_parent, r_via, n_via, r_kid, n_kid;
    t_mask              r_pmask, n_pmask;
    logic [COUNT_W-1:0] r_total, n_total, r_ocount, n_ocount;
    logic               r_ovalid, n_ovalid, r_ofull, n_ofull;

    logic [NODE_W-1:0]  w_edge_let, w_edge_c;
    logic [COUNT_W:0]   w_sum;
    logic [NODE_W-1:0]  w_new;

    // an edge never written reads as no child
    assign w_edge_let = r_msk_q[r_let] ? r_ch_q : '0;
    assign w_edge_c   = r_msk_q[r_c] ? r_ch_q : '0;
    assign w_sum      = {1'b0, r_total} + {1'b0, r_ec_q};
    assign w_new      = r_ncount[NODE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (ch_we) ch_mem[ch_waddr] <= ch_wdata;
        r_ch_q <= ch_mem[ch_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (msk_we) msk_mem[msk_waddr] <= msk_wdata;
        r_msk_q <= msk_mem[msk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
        r_fl_q <= fl_mem[fl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ec_we) ec_mem[ec_waddr] <= ec_wdata;
        r_ec_q <= ec_mem[ec_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (vm_we) vm_mem[vm_waddr] <= vm_wdata;
        r_vm_q <= vm_mem[vm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bo_we) bo_mem[bo_waddr] <= bo_wdata;
        r_bo_q <= bo_mem[bo_raddr];
    end

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_scan   = r_scan;
        n_ncount = r_ncount;
        n_olen   = r_olen;
        n_idx    = r_idx;
        n_ovf    = r_ovf;
        n_void   = r_void;
        n_built  = r_built;
        n_let    = r_let;
        n_c      = r_c;
        n_parent = r_parent;
        n_via    = r_via;
        n_kid    = r_kid;
        n_pmask  = r_pmask;
        n_total  = r_total;
        n_ocount = r_ocount;
        n_ofull  = r_ofull;
        n_ovalid = r_ovalid && !o_rsp.ready;
        o_pop    = 1'b0;

        ch_raddr  = '0;
        ch_waddr  = slot(r_cursor, r_let);
        ch_wdata  = '0;
        ch_we     = 1'b0;
        msk_raddr = '0;
        msk_waddr = '0;
        msk_wdata = '0;
        msk_we    = 1'b0;
        fl_raddr  = '0;
        fl_waddr  = '0;
        fl_wdata  = '0;
        fl_we     = 1'b0;
        ec_raddr  = '0;
        ec_waddr  = '0;
        ec_wdata  = '0;
        ec_we     = 1'b0;
        vm_raddr  = '0;
        vm_waddr  = '0;
        vm_wdata  = 1'b0;
        vm_we     = 1'b0;
        bo_raddr  = '0;
        bo_waddr  = r_olen[NODE_W-1:0];
        bo_wdata  = '0;
        bo_we     = 1'b0;

        unique case (r_state)
            S_INIT: begin
                // root row and root counters start empty
                msk_we  = 1'b1;
                ec_we   = 1'b1;
                vm_we   = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_let = i_op.letter[LET_W-1:0];
                    unique case (i_op.req_type)
                        REQ_PAT: begin
                            if (!r_built && !r_void) begin
                                ch_raddr  = slot(r_cursor, i_op.letter[LET_W-1:0]);
                                msk_raddr = r_cursor;
                                n_state   = S_PAT_RD;
                            end
                        end
                        REQ_ENDP: begin
                            if (!r_built) begin
                                ec_raddr = r_cursor;
                                n_state  = S_END_RD;
                            end
                        end
                        REQ_BUILD: begin
                            if (!r_built) begin
                                n_olen  = '0;
                                n_c     = '0;
                                n_state = S_BR_RQ;
                            end
                        end
                        REQ_TEXT: begin
                            ch_raddr  = slot(r_scan, i_op.letter[LET_W-1:0]);
                            msk_raddr = r_scan;
                            n_state   = S_TXT_RD;
                        end
                        REQ_ENDT: begin
                            n_idx   = r_olen;
                            n_state = S_FR_RQ;
                        end
                        REQ_CLEAR: begin
                            n_cursor = '0;
                            n_scan   = '0;
                            n_ncount = CNT_W'(1);
                            n_olen   = '0;
                            n_ovf    = 1'b0;
                            n_void   = 1'b0;
                            n_built  = 1'b0;
                            n_state  = S_INIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PAT_RD: begin
                if (w_edge_let != '0) begin
                    n_cursor = w_edge_let;
                    n_state  = S_IDLE;
                end else if (r_ncount >= CNT_W'(MAX_NODES)) begin
                    n_ovf   = 1'b1;
                    n_void  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ch_we     = 1'b1;
                    ch_wdata  = w_new;
                    msk_we    = 1'b1;
                    msk_waddr = r_cursor;
                    msk_wdata = r_msk_q | (t_mask'(1) << r_let);
                    fl_we     = 1'b1;
                    fl_waddr  = w_new;
                    ec_we     = 1'b1;
                    ec_waddr  = w_new;
                    vm_we     = 1'b1;
                    vm_waddr  = w_new;
                    n_cursor  = w_new;
                    n_kid     = w_new;
                    n_ncount  = r_ncount + 1'b1;
                    n_state   = S_PAT_NEW;
                end
            end
            S_PAT_NEW: begin
                msk_we    = 1'b1;
                msk_waddr = r_kid;
                n_state   = S_IDLE;
            end
            S_END_RD: begin
                if (!r_void && r_ec_q != COUNT_MAX) begin
                    ec_we    = 1'b1;
                    ec_waddr = r_cursor;
                    ec_wdata = r_ec_q + 1'b1;
                end
                n_cursor = '0;
                n_void   = 1'b0;
                n_state  = S_IDLE;
            end
            S_TXT_RD: begin
                n_scan   = w_edge_let;
                vm_we    = 1'b1;
                vm_waddr = w_edge_let;
                vm_wdata = 1'b1;
                n_state  = S_IDLE;
            end
            S_BR_RQ: begin
                ch_raddr = slot('0, r_c);
                n_state  = S_BR_DO;
            end
            S_BR_DO: begin
                if (w_edge_c != '0) begin
                    fl_we    = 1'b1;
                    fl_waddr = w_edge_c;
                    if (r_olen < CNT_W'(MAX_NODES)) begin
                        bo_we    = 1'b1;
                        bo_wdata = w_edge_c;
                        n_olen   = r_olen + 1'b1;
                    end
                end
                if (r_c == LAST_C) begin
                    n_idx   = '0;
                    n_state = S_BH;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = S_BR_RQ;
                end
            end
            S_BH: begin
                if (r_idx >= r_olen) begin
                    n_built = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    bo_raddr = r_idx[NODE_W-1:0];
                    n_state  = S_BPAR;
                end
            end
            S_BPAR: begin
                n_parent = r_bo_q;
                fl_raddr = r_bo_q;
                n_c      = '0;
                n_state  = S_BVIA;
            end
            S_BVIA: begin
                n_via   = r_fl_q;
                n_state = S_BC_RQ;
            end
            S_BC_RQ: begin
                ch_raddr  = slot(r_parent, r_c);
                msk_raddr = r_parent;
                n_state   = S_BC_KID;
            end
            S_BC_KID: begin
                n_kid     = w_edge_c;
                n_pmask   = r_msk_q;
                ch_raddr  = slot(r_via, r_c);
                msk_raddr = r_via;
                n_state   = S_BC_TGT;
            end
            S_BC_TGT: begin
                if (r_kid == '0) begin
                    // missing edge takes the failure target's edge
                    ch_we     = 1'b1;
                    ch_waddr  = slot(r_parent, r_c);
                    ch_wdata  = w_edge_c;
                    msk_we    = 1'b1;
                    msk_waddr = r_parent;
                    msk_wdata = r_pmask | (t_mask'(1) << r_c);
                end else begin
                    fl_we    = 1'b1;
                    fl_waddr = r_kid;
                    fl_wdata = w_edge_c;
                    if (r_olen < CNT_W'(MAX_NODES)) begin
                        bo_we    = 1'b1;
                        bo_wdata = r_kid;
                        n_olen   = r_olen + 1'b1;
                    end
                end
                if (r_c == LAST_C) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_BH;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = S_BC_RQ;
                end
            end
            S_FR_RQ: begin
                if (r_idx == '0) begin
                    n_total = '0;
                    n_state = S_FS_RQ;
                end else begin
                    bo_raddr = NODE_W'(r_idx - 1'b1);
                    n_state  = S_FR_ND;
                end
            end
            S_FR_ND: begin
                fl_raddr = r_bo_q;
                vm_raddr = r_bo_q;
                n_state  = S_FR_UP;
            end
            S_FR_UP: begin
                // a mark moves up its failure link
                if (r_vm_q) begin
                    vm_we    = 1'b1;
                    vm_waddr = r_fl_q;
                    vm_wdata = 1'b1;
                end
                n_idx   = r_idx - 1'b1;
                n_state = S_FR_RQ;
            end
            S_FS_RQ: begin
                if (r_idx >= r_ncount) begin
                    n_state = S_OUT;
                end else begin
                    vm_raddr = r_idx[NODE_W-1:0];
                    ec_raddr = r_idx[NODE_W-1:0];
                    n_state  = S_FS_DO;
                end
            end
            S_FS_DO: begin
                if (r_vm_q) begin
                    n_total = w_sum[COUNT_W] ? COUNT_MAX : w_sum[COUNT_W-1:0];
                end
                vm_we    = 1'b1;
                vm_waddr = r_idx[NODE_W-1:0];
                n_idx    = r_idx + 1'b1;
                n_state  = S_FS_RQ;
            end
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_ocount = r_total;
                    n_ofull  = r_ovf;
                    n_scan   = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cursor <= '0;
            r_scan   <= '0;
            r_ncount <= CNT_W'(1);
            r_olen   <= '0;
            r_idx    <= '0;
            r_ovf    <= 1'b0;
            r_void   <= 1'b0;
            r_built  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_scan   <= n_scan;
            r_ncount <= n_ncount;
            r_olen   <= n_olen;
            r_idx    <= n_idx;
            r_ovf    <= n_ovf;
            r_void   <= n_void;
            r_built  <= n_built;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_let    <= n_let;
        r_c      <= n_c;
        r_parent <= n_parent;
        r_via    <= n_via;
        r_kid    <= n_kid;
        r_pmask  <= n_pmask;
        r_total  <= n_total;
        r_ocount <= n_ocount;
        r_ofull  <= n_ofull;
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.match_count = r_ocount;
    assign o_rsp.table_full  = r_ofull;

endmodule
`default_nettype wire

// ===== sim/tb_multi_pattern_presence_counter.sv =====
`timescale 1ns / 1ps
module tb_multi_pattern_presence_counter;
    import mpc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;
    localparam int DRAIN_CYCLES = 3 * MAX_NODES + 2 * MAX_NODES + 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mpc_req_if req_bus ();
    mpc_rsp_if rsp_bus ();

    multi_pattern_presence_counter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    always #10 i_clk = ~i_clk;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               table_full;
    } t_report;

    typedef struct {
        logic [REQ_W-1:0]    req_type;
        logic [LETTER_W-1:0] letter;
        bit                  typed;
        t_report             want;
    } t_row;

    // automaton mirror
    logic [NODE_W-1:0]  goto_tbl [MAX_NODES*ALPHABET];
    logic [NODE_W-1:0]  fail_tbl [MAX_NODES];
    logic [COUNT_W-1:0] hits_tbl [MAX_NODES];
    bit                 seen_tbl [MAX_NODES];
    logic [NODE_W-1:0]  bfs_tbl  [MAX_NODES];
    int                 bfs_len;
    int                 nodes_used;
    logic [NODE_W-1:0]  ins_node;
    logic [NODE_W-1:0]  scan_node;
    bit                 full_seen;
    bit                 pat_lost;
    bit                 links_done;

    t_report report_q[$];
    int      errors = 0;
    int      items = 0;
    int      idle_mode = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void trie_reset();
        for (int i = 0; i < MAX_NODES * ALPHABET; i++) goto_tbl[i] = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            fail_tbl[i] = '0;
            hits_tbl[i] = '0;
            seen_tbl[i] = 1'b0;
            bfs_tbl[i]  = '0;
        end
        bfs_len = 0;
        nodes_used = 1;
        ins_node = '0;
        scan_node = '0;
        full_seen = 1'b0;
        pat_lost = 1'b0;
        links_done = 1'b0;
    endfunction

    function automatic void link_trie();
        logic [NODE_W-1:0] kid, up, tgt, par;
        bfs_len = 0;
        for (int c = 0; c < ALPHABET; c++) begin
            kid = goto_tbl[c];
            if (kid != 0) begin
                fail_tbl[kid] = '0;
                bfs_tbl[bfs_len++] = kid;
            end
        end
        for (int h = 0; h < bfs_len; h++) begin
            par = bfs_tbl[h];
            up  = fail_tbl[par];
            for (int c = 0; c < ALPHABET; c++) begin
                kid = goto_tbl[par * ALPHABET + c];
                tgt = goto_tbl[up * ALPHABET + c];
                if (kid == 0) begin
                    goto_tbl[par * ALPHABET + c] = tgt;
                end else begin
                    fail_tbl[kid] = tgt;
                    if (bfs_len < MAX_NODES) bfs_tbl[bfs_len++] = kid;
                end
            end
        end
        links_done = 1'b1;
    endfunction

    function automatic bit step_automaton(input logic [REQ_W-1:0] rq,
                                          input logic [LETTER_W-1:0] lt,
                                          output t_report rep);
        int kid, total;
        rep = '0;
        case (rq)
            REQ_PAT: begin
                if (!links_done && !pat_lost && lt < ALPHABET) begin
                    kid = goto_tbl[ins_node * ALPHABET + lt];
                    if (kid == 0 && nodes_used >= MAX_NODES) begin
                        full_seen = 1'b1;
                        pat_lost = 1'b1;
                    end else begin
                        if (kid == 0) begin
                            kid = nodes_used++;
                            for (int c = 0; c < ALPHABET; c++) goto_tbl[kid * ALPHABET + c] = '0;
                            fail_tbl[kid] = '0;
                            hits_tbl[kid] = '0;
                            seen_tbl[kid] = 1'b0;
                            goto_tbl[ins_node * ALPHABET + lt] = NODE_W'(kid);
                        end
                        ins_node = NODE_W'(kid);
                    end
                end
            end
            REQ_ENDP: begin
                if (!links_done) begin
                    if (!pat_lost && hits_tbl[ins_node] != COUNT_MAX)
                        hits_tbl[ins_node]++;
                    ins_node = '0;
                    pat_lost = 1'b0;
                end
            end
            REQ_BUILD: if (!links_done) link_trie();
            REQ_TEXT: begin
                if (lt < ALPHABET) begin
                    scan_node = goto_tbl[scan_node * ALPHABET + lt];
                    seen_tbl[scan_node] = 1'b1;
                end
            end
            REQ_ENDT: begin
                // marks flow up the failure links, deepest nodes first
                for (int i = bfs_len; i > 0; i--)
                    seen_tbl[fail_tbl[bfs_tbl[i-1]]] |= seen_tbl[bfs_tbl[i-1]];
                total = 0;
                for (int i = 0; i < nodes_used; i++) begin
                    if (seen_tbl[i]) begin
                        total += hits_tbl[i];
                        if (total > COUNT_MAX) total = COUNT_MAX;
                    end
                    seen_tbl[i] = 1'b0;
                end
                scan_node = '0;
                rep.match_count = COUNT_W'(total);
                rep.table_full = full_seen;
                return 1'b1;
            end
            REQ_CLEAR: trie_reset();
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic int send_gap_pct();
        return idle_mode == 0 ? 9 : (idle_mode == 1 ? 75 : 0);
    endfunction

    function automatic int stall_pct();
        return idle_mode == 0 ? 75 : (idle_mode == 1 ? 9 : 0);
    endfunction

    task automatic send_word(input logic [REQ_W-1:0] rq, input logic [LETTER_W-1:0] lt,
                             input bit typed = 1'b0, input t_report want = '0);
        t_report rep;
        bit      has;
        if ($urandom_range(99) < send_gap_pct()) begin
            req_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct());
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= rq;
        req_bus.letter   <= lt;
        do @(posedge i_clk); while (!req_bus.ready);
        has = step_automaton(rq, lt, rep);
        if (has) report_q.push_back(typed ? want : rep);
        items++;
    endtask

    task automatic wait_idle();
        if (report_q.size() != 0) begin
            req_bus.valid <= 1'b0;
            while (report_q.size() != 0) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_report exp_rep;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (report_q.size() == 0) begin
                report("unexpected word", rsp_bus.match_count, 0);
            end else begin
                exp_rep = report_q.pop_front();
                if (rsp_bus.match_count !== exp_rep.match_count)
                    report("match_count", rsp_bus.match_count, exp_rep.match_count);
                if (rsp_bus.table_full !== exp_rep.table_full)
                    report("table_full", rsp_bus.table_full, exp_rep.table_full);
            end
        end
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct());
    end

    task automatic random_session();
        int npat, plen, ntext, tlen, hi;
        send_word(REQ_CLEAR, '0);
        hi = ($urandom_range(3) == 0) ? ALPHABET - 1 : 3;
        npat = $urandom_range(1, 6);
        for (int p = 0; p < npat; p++) begin
            plen = $urandom_range(0, 4);
            for (int k = 0; k < plen; k++) begin
                if ($urandom_range(19) == 0)
                    send_word(logic'($urandom_range(1)) ? REQ_SPARE6 : REQ_SPARE7,
                              LETTER_W'($urandom));
                send_word(REQ_PAT, ($urandom_range(15) == 0) ? LETTER_W'($urandom_range(26, 31))
                                                             : LETTER_W'($urandom_range(hi)));
            end
            send_word(REQ_ENDP, LETTER_W'($urandom));
        end
        if ($urandom_range(99) < 85) send_word(REQ_BUILD, LETTER_W'($urandom));
        if ($urandom_range(9) == 0) begin
            send_word(REQ_PAT, LETTER_W'($urandom_range(hi)));
            send_word(REQ_ENDP, '0);
            send_word(REQ_BUILD, '0);
        end
        ntext = $urandom_range(1, 3);
        for (int t = 0; t < ntext; t++) begin
            tlen = $urandom_range(0, 30);
            for (int k = 0; k < tlen; k++)
                send_word(REQ_TEXT, ($urandom_range(15) == 0) ? LETTER_W'($urandom_range(26, 31))
                                                              : LETTER_W'($urandom_range(hi)));
            send_word(REQ_ENDT, LETTER_W'($urandom));
        end
    endtask

    t_row rows[$];

    task automatic add_row(input logic [REQ_W-1:0] rq, input logic [LETTER_W-1:0] lt,
                           input bit typed = 1'b0, input int cnt = 0, input bit full = 1'b0);
        t_row r;
        r.req_type = rq;
        r.letter = lt;
        r.typed = typed;
        r.want.match_count = COUNT_W'(cnt);
        r.want.table_full = full;
        rows.push_back(r);
    endtask

    initial begin
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_CLEAR;
        req_bus.letter   <= '0;
        trie_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(REQ_ENDT, 5'd0, 1'b1, 0);
        add_row(REQ_PAT, 5'd0);
        add_row(REQ_ENDP, 5'd0);
        add_row(REQ_PAT, 5'd25);
        add_row(REQ_ENDP, 5'd31);
        add_row(REQ_PAT, 5'd26);
        add_row(REQ_PAT, 5'd31);
        add_row(REQ_SPARE6, 5'd31);
        add_row(REQ_SPARE7, 5'd0);
        add_row(REQ_TEXT, 5'd0);
        add_row(REQ_ENDT, 5'd0, 1'b1, 1);
        add_row(REQ_BUILD, 5'd0);
        add_row(REQ_BUILD, 5'd0);
        add_row(REQ_PAT, 5'd1);
        add_row(REQ_ENDP, 5'd0);
        add_row(REQ_TEXT, 5'd25);
        add_row(REQ_TEXT, 5'd31);
        add_row(REQ_ENDT, 5'd0, 1'b1, 1);
        add_row(REQ_CLEAR, 5'd0);
        add_row(REQ_ENDP, 5'd0);
        add_row(REQ_BUILD, 5'd0);
        add_row(REQ_ENDT, 5'd0, 1'b1, 0);
        add_row(REQ_TEXT, 5'd3);
        add_row(REQ_ENDT, 5'd0, 1'b1, 1);
        foreach (rows[i]) send_word(rows[i].req_type, rows[i].letter, rows[i].typed, rows[i].want);

        // sender holds off until every owed word is back
        wait_idle();

        while (items < 470) begin
            idle_mode = items < 170 ? 0 : (items < 330 ? 1 : 2);
            if ($urandom_range(7) == 0) wait_idle();
            random_session();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (report_q.size() != 0) report("words still owed", 0, report_q.size());
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #80ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== files.f =====
sv/mpc_pkg.sv
sv/mpc_if.sv
sv/mpc_front.sv
sv/mpc_fifo.sv
sv/mpc_back.sv
sv/multi_pattern_presence_counter.sv
sim/tb_multi_pattern_presence_counter.sv
